@@ rtl/core/rfs_pkg.sv @@
// Shared types and constants for the rectangle fill store.
package rfs_pkg;

   localparam int DATA_W      = 32;
   localparam int ROW_W       = 6;
   localparam int COL_W       = 6;
   localparam int CFG_W       = 7;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 1;

   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 64;

   localparam logic [CFG_W-1:0] ROWS_USED_RESET = 7'd64;
   localparam logic [CFG_W-1:0] COLS_USED_RESET = 7'd64;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_USED = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_USED = 1'd1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_FILL = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_READ
   } state_type;

endpackage

@@ rtl/core/rfs_req_if.sv @@
// Request channel: load, fill or read beat.
interface rfs_req_if;
   logic                               valid;
   logic                               ready;
   logic [rfs_pkg::OP_W-1:0]           opcode;
   logic [rfs_pkg::ROW_W-1:0]          top_row;
   logic [rfs_pkg::COL_W-1:0]          left_col;
   logic [rfs_pkg::ROW_W-1:0]          bottom_row;
   logic [rfs_pkg::COL_W-1:0]          right_col;
   logic signed [rfs_pkg::DATA_W-1:0]  cell_value;

   modport source (
      output valid, opcode, top_row, left_col, bottom_row, right_col, cell_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, top_row, left_col, bottom_row, right_col, cell_value,
      output ready
   );
endinterface

@@ rtl/core/rfs_rsp_if.sv @@
// Response channel: read result beat.
interface rfs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rfs_pkg::DATA_W-1:0]  read_value;
   logic                               out_of_range;

   modport source (
      output valid, read_value, out_of_range,
      input  ready
   );
   modport sink (
      input  valid, read_value, out_of_range,
      output ready
   );
endinterface

@@ rtl/core/rfs_csr_if.sv @@
// Configuration write channel.
interface rfs_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rfs_pkg::CSR_INDEX_W-1:0]    index;
   logic [rfs_pkg::CFG_W-1:0]          data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

@@ rtl/core/rfs_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module rfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/rfs_grid.sv @@
// Grid storage: one RAM bank per column, all banks share the row address.
module rfs_grid #(
   parameter int MAX_ROWS = rfs_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = rfs_pkg::DEFAULT_MAX_COLS,
   localparam int RA      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                                      clock,
   input  logic [RA-1:0]                             mem_addr,
   input  logic [rfs_pkg::DATA_W-1:0]                mem_wdata,
   input  logic [MAX_COLS-1:0]                       mem_wmask,
   input  logic                                      mem_rd_en,
   output logic [MAX_COLS-1:0][rfs_pkg::DATA_W-1:0]  mem_rdata
);

   for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
      rfs_ram #(
         .WIDTH (rfs_pkg::DATA_W),
         .DEPTH (MAX_ROWS)
      ) u_bank (
         .clock (clock),
         .wr_en (mem_wmask[j]),
         .rd_en (mem_rd_en),
         .addr  (mem_addr),
         .wdata (mem_wdata),
         .rdata (mem_rdata[j])
      );
   end

endmodule

@@ rtl/core/rfs_ctrl.sv @@
// Sequencer: clear sweep, load, row-by-row fill, read and response register.
module rfs_ctrl #(
   parameter int MAX_ROWS = rfs_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = rfs_pkg::DEFAULT_MAX_COLS,
   localparam int RA      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int CA      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                                      clock,
   input  logic                                      reset,
   rfs_req_if.sink                                   req_bus,
   rfs_rsp_if.source                                 rsp_bus,
   input  logic [rfs_pkg::CFG_W-1:0]                 rows_in_use,
   input  logic [rfs_pkg::CFG_W-1:0]                 cols_in_use,
   output logic [RA-1:0]                             mem_addr,
   output logic [rfs_pkg::DATA_W-1:0]                mem_wdata,
   output logic [MAX_COLS-1:0]                       mem_wmask,
   output logic                                      mem_rd_en,
   input  logic [MAX_COLS-1:0][rfs_pkg::DATA_W-1:0]  mem_rdata
);

   rfs_pkg::state_type            state_ff, state_in;
   logic [RA-1:0]                 row_ff, row_in;
   logic [RA-1:0]                 last_ff, last_in;
   logic [rfs_pkg::COL_W-1:0]     col_lo_ff, col_lo_in;
   logic [rfs_pkg::COL_W-1:0]     col_hi_ff, col_hi_in;
   logic [rfs_pkg::DATA_W-1:0]    value_ff, value_in;
   logic                          oor_ff, oor_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rfs_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                          rsp_oor_ff, rsp_oor_in;

   logic                          accept;
   logic                          cell_ok;
   logic                          fill_ok;
   logic                          rsp_free;
   logic [rfs_pkg::ROW_W-1:0]     last_row;
   logic [rfs_pkg::COL_W-1:0]     last_col;

   assign req_bus.ready = (state_ff == rfs_pkg::ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign cell_ok = ({1'b0, req_bus.top_row} < rows_in_use) &&
                    ({1'b0, req_bus.left_col} < cols_in_use);
   assign fill_ok = cell_ok && (req_bus.top_row <= req_bus.bottom_row) &&
                    (req_bus.left_col <= req_bus.right_col);

   assign last_row = ({1'b0, req_bus.bottom_row} >= rows_in_use) ?
                     rfs_pkg::ROW_W'(rows_in_use - 7'd1) : req_bus.bottom_row;
   assign last_col = ({1'b0, req_bus.right_col} >= cols_in_use) ?
                     rfs_pkg::COL_W'(cols_in_use - 7'd1) : req_bus.right_col;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfs_pkg::ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      col_lo_ff    <= col_lo_in;
      col_hi_ff    <= col_hi_in;
      value_ff     <= value_in;
      oor_ff       <= oor_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      col_lo_in    = col_lo_ff;
      col_hi_in    = col_hi_ff;
      value_in     = value_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      mem_addr     = row_ff;
      mem_wdata    = value_ff;
      mem_wmask    = '0;
      mem_rd_en    = 1'b0;

      case (state_ff)
         rfs_pkg::ST_CLEAR: begin
            mem_wdata = '0;
            mem_wmask = '1;
            row_in    = row_ff + 1'b1;
            if (row_ff == RA'(MAX_ROWS - 1)) begin
               state_in = rfs_pkg::ST_IDLE;
            end
         end
         rfs_pkg::ST_IDLE: begin
            if (accept) begin
               case (rfs_pkg::opcode_type'(req_bus.opcode))
                  rfs_pkg::OP_LOAD: begin
                     mem_addr  = RA'(req_bus.top_row);
                     mem_wdata = req_bus.cell_value;
                     for (int j = 0; j < MAX_COLS; j++) begin
                        mem_wmask[j] = cell_ok && (int'(req_bus.left_col) == j);
                     end
                  end
                  rfs_pkg::OP_FILL: begin
                     if (fill_ok) begin
                        row_in    = RA'(req_bus.top_row);
                        last_in   = RA'(last_row);
                        col_lo_in = req_bus.left_col;
                        col_hi_in = last_col;
                        value_in  = req_bus.cell_value;
                        state_in  = rfs_pkg::ST_FILL;
                     end
                  end
                  rfs_pkg::OP_READ: begin
                     mem_addr  = RA'(req_bus.top_row);
                     mem_rd_en = 1'b1;
                     col_lo_in = req_bus.left_col;
                     oor_in    = !cell_ok;
                     state_in  = rfs_pkg::ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rfs_pkg::ST_FILL: begin
            for (int j = 0; j < MAX_COLS; j++) begin
               mem_wmask[j] = (j >= int'(col_lo_ff)) && (j <= int'(col_hi_ff));
            end
            row_in = row_ff + 1'b1;
            if (row_ff == last_ff) begin
               state_in = rfs_pkg::ST_IDLE;
            end
         end
         rfs_pkg::ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = oor_ff ? '0 : mem_rdata[CA'(col_lo_ff)];
               rsp_oor_in   = oor_ff;
               state_in     = rfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rfs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.read_value   = rsp_value_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

endmodule

@@ rtl/core/rectangle_fill_store_unit.sv @@
// Rectangle fill store: per-cell load, clipped rectangle fill, cell read.
// Load: the cell is written as the request beat is taken. Read: the RAM read is
// registered, then the result beat waits for a free response register and holds
// the input off while it waits. Fill: a start step, then one clipped row per cycle
// (up to MAX_ROWS), set by the single row port shared by all column banks; one item
// in flight at a time. After reset the grid is zeroed one row a cycle, before the
// first request is taken; configuration registers reset to 64 rows and 64 columns.
module rectangle_fill_store_unit #(
   parameter int MAX_ROWS = rfs_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = rfs_pkg::DEFAULT_MAX_COLS,
   localparam int RA      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic       clock,
   input  logic       reset,
   rfs_req_if.sink    req_bus,
   rfs_rsp_if.source  rsp_bus,
   rfs_csr_if.sink    csr_bus
);

   logic [rfs_pkg::CFG_W-1:0]                 rows_used_ff, rows_used_in;
   logic [rfs_pkg::CFG_W-1:0]                 cols_used_ff, cols_used_in;
   logic [rfs_pkg::CFG_W-1:0]                 rows_in_use;
   logic [rfs_pkg::CFG_W-1:0]                 cols_in_use;

   logic [RA-1:0]                             mem_addr;
   logic [rfs_pkg::DATA_W-1:0]                mem_wdata;
   logic [MAX_COLS-1:0]                       mem_wmask;
   logic                                      mem_rd_en;
   logic [MAX_COLS-1:0][rfs_pkg::DATA_W-1:0]  mem_rdata;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            rfs_pkg::CSR_ROWS_USED: rows_used_in = csr_bus.data;
            rfs_pkg::CSR_COLS_USED: cols_used_in = csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= rfs_pkg::ROWS_USED_RESET;
         cols_used_ff <= rfs_pkg::COLS_USED_RESET;
      end else begin
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
      end
   end

   // values above the grid size count as the full grid
   assign rows_in_use = (int'(rows_used_ff) > MAX_ROWS) ?
                        rfs_pkg::CFG_W'(MAX_ROWS) : rows_used_ff;
   assign cols_in_use = (int'(cols_used_ff) > MAX_COLS) ?
                        rfs_pkg::CFG_W'(MAX_COLS) : cols_used_ff;

   rfs_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .rows_in_use (rows_in_use),
      .cols_in_use (cols_in_use),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_wmask   (mem_wmask),
      .mem_rd_en   (mem_rd_en),
      .mem_rdata   (mem_rdata)
   );

   rfs_grid #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_grid (
      .clock     (clock),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_wmask (mem_wmask),
      .mem_rd_en (mem_rd_en),
      .mem_rdata (mem_rdata)
   );

endmodule

@@ dv/rfs_store_checker.sv @@
// Checker for the rectangle fill store: mirrors the grid, predicts read beats, compares them.
module rfs_store_checker (
   input  logic clock,
   input  logic reset,
   rfs_req_if   req_mon,
   rfs_rsp_if   rsp_mon,
   rfs_csr_if   csr_mon,
   output int   mismatch_count,
   output int   reads_waiting,
   output int   reads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [rfs_pkg::DATA_W-1:0] value;
      logic                       out_of_range;
   } read_beat_t;

   logic [rfs_pkg::DATA_W-1:0] cell_mirror [rfs_pkg::DEFAULT_MAX_ROWS][rfs_pkg::DEFAULT_MAX_COLS];
   logic [rfs_pkg::CFG_W-1:0]  rows_reg;
   logic [rfs_pkg::CFG_W-1:0]  cols_reg;
   read_beat_t                 expected_reads[$];

   function automatic int unsigned in_use(input logic [rfs_pkg::CFG_W-1:0] reg_value,
                                          input int unsigned limit);
      return (reg_value > limit) ? limit : reg_value;
   endfunction

   task automatic note_mismatch(input string what, input read_beat_t want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t read beat %s: expected value %h flag %b, got value %h flag %b",
                  $realtime, what, want.value, want.out_of_range,
                  rsp_mon.read_value, rsp_mon.out_of_range);
   endtask

   task automatic apply_request(input logic [rfs_pkg::OP_W-1:0] op,
                                input logic [rfs_pkg::ROW_W-1:0] r1,
                                input logic [rfs_pkg::COL_W-1:0] c1,
                                input logic [rfs_pkg::ROW_W-1:0] r2,
                                input logic [rfs_pkg::COL_W-1:0] c2,
                                input logic [rfs_pkg::DATA_W-1:0] v);
      int unsigned nr, nc, last_r, last_c, r, c;
      read_beat_t beat;
      nr = in_use(rows_reg, rfs_pkg::DEFAULT_MAX_ROWS);
      nc = in_use(cols_reg, rfs_pkg::DEFAULT_MAX_COLS);
      case (op)
         rfs_pkg::OP_LOAD: begin
            if (r1 < nr && c1 < nc) cell_mirror[r1][c1] = v;
         end
         rfs_pkg::OP_FILL: begin
            if (r1 <= r2 && c1 <= c2 && r1 < nr && c1 < nc) begin
               last_r = (r2 >= nr) ? nr - 1 : r2;
               last_c = (c2 >= nc) ? nc - 1 : c2;
               for (r = r1; r <= last_r; r++)
                  for (c = c1; c <= last_c; c++)
                     cell_mirror[r][c] = v;
            end
         end
         rfs_pkg::OP_READ: begin
            if (r1 < nr && c1 < nc) begin
               beat.value        = cell_mirror[r1][c1];
               beat.out_of_range = 1'b0;
            end else begin
               beat.value        = '0;
               beat.out_of_range = 1'b1;
            end
            expected_reads.insert(expected_reads.size(), beat);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      read_beat_t want;
      if (reset) begin
         foreach (cell_mirror[r, c]) cell_mirror[r][c] = '0;
         rows_reg = rfs_pkg::ROWS_USED_RESET;
         cols_reg = rfs_pkg::COLS_USED_RESET;
         expected_reads.delete();
         mismatch_count = 0;
         reads_checked  = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               rfs_pkg::CSR_ROWS_USED: rows_reg = csr_mon.data;
               rfs_pkg::CSR_COLS_USED: cols_reg = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reads.size() == 0) begin
               want = '0;
               note_mismatch("with nothing outstanding", want);
            end else begin
               want = expected_reads.pop_front();
               reads_checked++;
               if (want.value !== rsp_mon.read_value ||
                   want.out_of_range !== rsp_mon.out_of_range)
                  note_mismatch("differs", want);
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.opcode, req_mon.top_row, req_mon.left_col,
                          req_mon.bottom_row, req_mon.right_col, req_mon.cell_value);
      end
      reads_waiting = expected_reads.size();
   end

endmodule

@@ dv/testbench.sv @@
// Top of the rectangle fill store bench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rfs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_GAP      = 12;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 400000;

   logic clock;
   logic reset;
   int   cycle_count;
   int   mismatch_count, reads_waiting, reads_checked;
   int   beats_sent, settings_used;
   int   rows_span, cols_span;
   int   recent_row, recent_col;
   bit   quiet_stretch;
   bit   long_hold_req;

   rfs_req_if req_ch ();
   rfs_rsp_if rsp_ch ();
   rfs_csr_if csr_ch ();

   rectangle_fill_store_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   rfs_store_checker store_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatch_count (mismatch_count),
      .reads_waiting  (reads_waiting),
      .reads_checked  (reads_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   task automatic issue(input logic [rfs_pkg::OP_W-1:0] op,
                        input logic [rfs_pkg::ROW_W-1:0] r1,
                        input logic [rfs_pkg::COL_W-1:0] c1,
                        input logic [rfs_pkg::ROW_W-1:0] r2,
                        input logic [rfs_pkg::COL_W-1:0] c2,
                        input logic [rfs_pkg::DATA_W-1:0] v);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.top_row    <= r1;
      req_ch.left_col   <= c1;
      req_ch.bottom_row <= r2;
      req_ch.right_col  <= c2;
      req_ch.cell_value <= v;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
   endtask

   // wait until the store is idle: all reads back and any fill finished
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (reads_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input logic [rfs_pkg::CFG_W-1:0] rows,
                           input logic [rfs_pkg::CFG_W-1:0] cols);
      settle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= rfs_pkg::CSR_ROWS_USED;
      csr_ch.data  <= rows;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= rfs_pkg::CSR_COLS_USED;
      csr_ch.data  <= cols;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      rows_span = (rows > rfs_pkg::DEFAULT_MAX_ROWS) ? rfs_pkg::DEFAULT_MAX_ROWS : rows;
      cols_span = (cols > rfs_pkg::DEFAULT_MAX_COLS) ? rfs_pkg::DEFAULT_MAX_COLS : cols;
      settings_used++;
   endtask

   // mostly near the grid in use, sometimes anywhere
   function automatic logic [5:0] pick_coord(input int span);
      if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, (span > 62) ? 63 : span + 1));
   endfunction

   task automatic random_item();
      int pick, height, width;
      logic [rfs_pkg::OP_W-1:0]   op;
      logic [rfs_pkg::ROW_W-1:0]  r1, r2;
      logic [rfs_pkg::COL_W-1:0]  c1, c2;
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = rfs_pkg::OP_LOAD;
      else if (pick < 55) op = rfs_pkg::OP_FILL;
      else if (pick < 95) op = rfs_pkg::OP_READ;
      else                op = OP_UNUSED;
      r1 = pick_coord(rows_span);
      c1 = pick_coord(cols_span);
      r2 = rfs_pkg::ROW_W'($urandom);
      c2 = rfs_pkg::COL_W'($urandom);
      if (op == rfs_pkg::OP_READ && $urandom_range(0, 1) == 1) begin
         r1 = rfs_pkg::ROW_W'(recent_row);
         c1 = rfs_pkg::COL_W'(recent_col);
      end
      if (op == rfs_pkg::OP_FILL) begin
         height = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
         width  = $urandom_range(0, 63);
         r2 = (int'(r1) + height > 63) ? 6'd63 : rfs_pkg::ROW_W'(int'(r1) + height);
         c2 = (int'(c1) + width > 63) ? 6'd63 : rfs_pkg::COL_W'(int'(c1) + width);
         if ($urandom_range(0, 9) == 0) {r1, r2} = {r2, r1};
         if ($urandom_range(0, 9) == 0) {c1, c2} = {c2, c1};
      end
      if (op == rfs_pkg::OP_LOAD || op == rfs_pkg::OP_FILL) begin
         recent_row = r1;
         recent_col = c1;
      end
      issue(op, r1, c1, r2, c2, $urandom);
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0) quiet_stretch = !quiet_stretch;
         random_item();
      end
      quiet_stretch = 1'b0;
   endtask

   // result receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (long_hold_req) begin
            stall = HOLD_CYCLES;
            long_hold_req = 1'b0;
         end else begin
            stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= rfs_pkg::OP_LOAD;
      req_ch.top_row     <= '0;
      req_ch.left_col    <= '0;
      req_ch.bottom_row  <= '0;
      req_ch.right_col   <= '0;
      req_ch.cell_value  <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= rfs_pkg::CSR_ROWS_USED;
      csr_ch.data        <= '0;
      quiet_stretch      = 1'b0;
      long_hold_req      = 1'b0;
      beats_sent         = 0;
      settings_used      = 0;
      rows_span          = rfs_pkg::DEFAULT_MAX_ROWS;
      cols_span          = rfs_pkg::DEFAULT_MAX_COLS;
      recent_row         = 0;
      recent_col         = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, extreme values, inverted and single-cell fills, unused opcode
      issue(rfs_pkg::OP_READ, 0, 0, 0, 0, 0);
      issue(rfs_pkg::OP_LOAD, 0, 0, 0, 0, 32'h8000_0000);
      issue(rfs_pkg::OP_LOAD, 63, 63, 0, 0, 32'h7fff_ffff);
      issue(rfs_pkg::OP_LOAD, 0, 63, 0, 0, 32'hffff_ffff);
      issue(rfs_pkg::OP_READ, 0, 0, 0, 0, 0);
      issue(rfs_pkg::OP_READ, 63, 63, 0, 0, 0);
      issue(rfs_pkg::OP_READ, 0, 63, 0, 0, 0);
      issue(rfs_pkg::OP_FILL, 10, 5, 9, 20, 32'h0000_1111);
      issue(rfs_pkg::OP_FILL, 3, 40, 20, 39, 32'h0000_2222);
      issue(rfs_pkg::OP_READ, 10, 5, 0, 0, 0);
      issue(rfs_pkg::OP_FILL, 5, 5, 5, 5, 32'hffff_fffe);
      issue(rfs_pkg::OP_READ, 5, 5, 0, 0, 0);
      issue(OP_UNUSED, 5, 5, 5, 5, 32'h1234_5678);
      issue(rfs_pkg::OP_READ, 5, 5, 0, 0, 0);
      issue(rfs_pkg::OP_FILL, 0, 0, 63, 63, 32'h5a5a_5a5a);
      issue(rfs_pkg::OP_READ, 63, 0, 0, 0, 0);

      // small grid: ignored loads, clipped and outside fills, out-of-range reads
      set_grid(8, 5);
      issue(rfs_pkg::OP_LOAD, 8, 0, 0, 0, 32'h0bad_0001);
      issue(rfs_pkg::OP_LOAD, 0, 5, 0, 0, 32'h0bad_0002);
      issue(rfs_pkg::OP_FILL, 6, 3, 63, 63, 32'hc3c3_c3c3);
      issue(rfs_pkg::OP_FILL, 8, 0, 9, 4, 32'h0bad_0003);
      issue(rfs_pkg::OP_READ, 7, 4, 0, 0, 0);
      issue(rfs_pkg::OP_READ, 8, 0, 0, 0, 0);
      issue(rfs_pkg::OP_READ, 0, 5, 0, 0, 0);

      // no rows in use
      set_grid(0, 64);
      issue(rfs_pkg::OP_LOAD, 0, 0, 0, 0, 32'h0bad_0004);
      issue(rfs_pkg::OP_READ, 0, 0, 0, 0, 0);

      // registers above the maximum; cells outside the small grid kept their values
      set_grid(127, 127);
      issue(rfs_pkg::OP_READ, 63, 63, 0, 0, 0);
      issue(rfs_pkg::OP_READ, 8, 0, 0, 0, 0);

      run_random(40);
      long_hold_req = 1'b1;
      quiet_stretch = 1'b1;
      repeat (30) random_item();
      quiet_stretch = 1'b0;
      run_random(20);

      set_grid(1, 1);    run_random(30);
      set_grid(64, 1);   run_random(30);
      set_grid(1, 64);   run_random(30);
      set_grid(0, 0);    run_random(20);
      set_grid(7, 0);    run_random(15);
      set_grid(8, 5);    run_random(40);
      set_grid(rfs_pkg::CFG_W'($urandom_range(1, 64)), rfs_pkg::CFG_W'($urandom_range(1, 64)));
      run_random(40);
      set_grid(rfs_pkg::CFG_W'($urandom_range(1, 64)), rfs_pkg::CFG_W'($urandom_range(1, 64)));
      run_random(40);
      set_grid(64, 64);  run_random(60);

      settle();
      $display("%0d request beats over %0d grid settings, %0d read beats checked",
               beats_sent, settings_used, reads_checked);
      $display("%0d mismatches, %0d reads outstanding", mismatch_count, reads_waiting);
      if (mismatch_count == 0 && reads_waiting == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/rfs_pkg.sv
rtl/core/rfs_req_if.sv
rtl/core/rfs_rsp_if.sv
rtl/core/rfs_csr_if.sv
rtl/core/rfs_ram.sv
rtl/core/rfs_grid.sv
rtl/core/rfs_ctrl.sv
rtl/core/rectangle_fill_store_unit.sv
dv/rfs_store_checker.sv
dv/testbench.sv
